// ===== hw/rtl/smpq_pkg.sv =====
package smpq_pkg;

    // Default number of cells in the chain
    localparam int QUEUE_DEPTH_DEFAULT = 256;

    localparam int PRIO_W  = 32;
    localparam int PAY_W   = 16;
    localparam int COUNT_W = 9;

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_DONE         = 2'd0,
        ST_REMOVE_EMPTY = 2'd1,
        ST_INSERT_FULL  = 2'd2
    } status_t;

    // Request from the producer
    typedef struct packed
    {
        action_t             action;
        logic [PRIO_W-1:0]   priority_req;
        logic [PAY_W-1:0]    payload;
    } req_t;

    // Response to the consumer
    typedef struct packed
    {
        logic [PAY_W-1:0]    out_payload;
        logic [PRIO_W-1:0]   out_priority;
        status_t             status;
        logic                is_empty;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    // One queue entry as held in a cell
    typedef struct packed
    {
        logic [PRIO_W-1:0]   prio;
        logic [PAY_W-1:0]    payload;
    } entry_t;

    // Broadcast command to every cell
    typedef struct packed
    {
        logic    insert;
        logic    remove;
        entry_t  new_ent;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/smpq_cell.sv =====
module smpq_cell (
    input  logic               clk,
    input  smpq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  smpq_pkg::entry_t   left_ent,
    input  logic               left_keep,
    input  smpq_pkg::entry_t   right_ent,
    output smpq_pkg::entry_t   ent,
    output logic               keep
);
    import smpq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    // Entry stays put on insert when it sorts at or before the new one
    assign keep = occupied && (ent_reg.prio <= cmd.new_ent.prio);
    assign ent  = ent_reg;

    // Insert: keep, take the new entry, or shift in from the left.
    // Remove: shift in from the right.
    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.insert)
        begin
            if (keep)
                ent_next = ent_reg;
            else if (left_keep)
                ent_next = cmd.new_ent;
            else
                ent_next = left_ent;
        end
        else if (cmd.remove)
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== hw/rtl/sorted_min_priority_queue.sv =====
// Sorted min-priority queue built as a chain of QUEUE_DEPTH cells, head in
// cell 0. Each request is broadcast to every cell; on insert every cell
// compares its priority with the new one at the same time and either holds,
// takes the new entry, or takes its left neighbor, so equal priorities leave
// in arrival order. A remove shifts the whole chain one cell toward the
// head. One request is accepted per cycle when not stalled, and its
// response is captured in the output register; the per-cell 32-bit
// compare plus the three-way select is the critical path. Stalls on the
// response side hold off new requests only while the output register is
// full and not taken. Inserts into a full queue and removes from an empty
// one leave the state unchanged and are reported in the status field.
module sorted_min_priority_queue #(
    parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  smpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output smpq_pkg::rsp_t rsp
);
    import smpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    cell_cmd_t     cmd;
    entry_t        ents  [QUEUE_DEPTH];
    logic          keeps [QUEUE_DEPTH];

    logic          accept;
    logic          full;
    logic          empty;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Request decode and response build
    always_comb
    begin
        cmd.insert          = 1'b0;
        cmd.remove          = 1'b0;
        cmd.new_ent.prio    = req.priority_req;
        cmd.new_ent.payload = req.payload;
        count_next          = count_reg;
        rsp_next            = rsp_reg;
        if (accept)
        begin
            rsp_next.out_payload  = '0;
            rsp_next.out_priority = '0;
            rsp_next.status       = ST_DONE;
            unique case (req.action)
                ACT_INSERT:
                begin
                    if (full)
                        rsp_next.status = ST_INSERT_FULL;
                    else
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (empty)
                        rsp_next.status = ST_REMOVE_EMPTY;
                    else
                    begin
                        cmd.remove            = 1'b1;
                        count_next            = count_reg - 1'b1;
                        rsp_next.out_payload  = ents[0].payload;
                        rsp_next.out_priority = ents[0].prio;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_DONE;
                end
            endcase
            rsp_next.is_empty    = (count_next == '0);
            rsp_next.entry_count = COUNT_W'(count_next);
        end
    end

    // Output register handshake
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        entry_t left_ent;
        logic   left_keep;
        entry_t right_ent;

        if (i == 0)
        begin : g_head
            assign left_ent  = cmd.new_ent;
            assign left_keep = 1'b1;
        end
        else
        begin : g_mid
            assign left_ent  = ents[i-1];
            assign left_keep = keeps[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_ent = '0;
        end
        else
        begin : g_next
            assign right_ent = ents[i+1];
        end

        smpq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (IDX < count_reg),
            .left_ent  (left_ent),
            .left_keep (left_keep),
            .right_ent (right_ent),
            .ent       (ents[i]),
            .keep      (keeps[i])
        );
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (ents[0].prio <= ents[1].prio))
        else $error("head entries out of order");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_INSERT && full) |=>
        (count_reg == $past(count_reg) && rsp.status == ST_INSERT_FULL))
        else $error("insert on full queue changed state");

    a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_REMOVE && !empty) |=>
        (rsp.out_priority == $past(ents[0].prio)
         && count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not return head");

endmodule
